// ===== sv/mfdl_pkg.sv =====
// shared types and constants for the modulated fractional delay line
// no dependencies; imported by the interface users, controller, datapath and top level
`default_nettype none

package mfdl_pkg;

  localparam int LINE_LENGTH_DEFAULT = 4096;
  localparam int FRAC_BITS           = 8;
  localparam int SAMPLE_W            = 24;
  localparam int DELAY_W             = 24;
  localparam int GAIN_W              = 15;
  localparam int GAIN_FRAC           = 15;
  localparam int CFG_INDEX_W         = 8;
  localparam int CFG_VALUE_W         = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INTERPOLATE_ENABLE = CFG_INDEX_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic        [DELAY_W-1:0]  delay_q8;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_VALUE_W-1:0] value;
  } cfg_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_MUL,
    S_MIX,
    S_SCALE,
    S_WRITE
  } state_t;

  // controller to datapath, at most one step of the item schedule per cycle
  typedef struct packed {
    logic load_in;
    logic calc_addr;
    logic mem_read;
    logic mul;
    logic mix;
    logic scale;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/mfdl_stream_if.sv =====
// valid/ready channel carrying one item of type T
// no dependencies; the payload type comes from the instantiating module
`default_nettype none

interface mfdl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== sv/mfdl_ctrl.sv =====
// item sequencer for the delay line: walks each item through address, read,
// interpolate, feedback and write-back steps; depends on mfdl_pkg
`default_nettype none

module mfdl_ctrl
  import mfdl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_ADDR;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_MUL;
      S_MUL:   state_next = S_MIX;
      S_MIX:   state_next = S_SCALE;
      S_SCALE: state_next = S_WRITE;
      S_WRITE: if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_ADDR:  cmd.calc_addr = 1'b1;
      S_READ:  cmd.mem_read  = 1'b1;
      S_MUL:   cmd.mul       = 1'b1;
      S_MIX:   cmd.mix       = 1'b1;
      S_SCALE: cmd.scale     = 1'b1;
      S_WRITE: cmd.commit    = status.out_free;
      default: cmd = '0;
    endcase
  end

  // a result only goes out when the output register can take it
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("commit while output register is occupied");

  // an accepted item goes straight on to address computation
  a_load_then_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> cmd.calc_addr)
    else $error("accepted item not followed by address step");

  // read data is consumed in the cycle after the read
  a_read_then_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_read |=> cmd.mul)
    else $error("memory read not followed by interpolation multiply");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath step commanded");

endmodule

`default_nettype wire

// ===== sv/mfdl_datapath.sv =====
// delay line storage, read address arithmetic, interpolation, feedback
// and output register; depends on mfdl_pkg, driven by mfdl_ctrl
`default_nettype none

module mfdl_datapath
  import mfdl_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_t      cmd,
  output status_t        status,
  input  wire in_item_t  in_item,
  input  wire logic      cfg_valid,
  input  wire cfg_item_t cfg_item,
  input  wire logic      out_ready,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int AW     = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
  localparam int PW     = AW + FRAC_BITS;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int FB_W   = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W  = SAMPLE_W + 2;

  localparam logic [DELAY_W-1:0] DMAX = DELAY_W'((LINE_LENGTH - 1) << FRAC_BITS);
  localparam logic [PW:0]        SPAN = (PW+1)'(LINE_LENGTH << FRAC_BITS);
  localparam logic [AW-1:0]      LAST = AW'(LINE_LENGTH - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (SAMPLE_W - 1));

  // configuration registers
  logic [GAIN_W-1:0] gain;
  logic              interp;

  // pointer and fill state
  logic [AW-1:0] wp;
  logic          wrapped;

  // per-item registers
  logic signed [SAMPLE_W-1:0] x;
  logic [PW-1:0]              dclamp;
  logic [AW-1:0]              idx;
  logic [AW-1:0]              nxt;
  logic [FRAC_BITS-1:0]       frac;
  logic                       v0;
  logic                       v1;
  logic signed [SAMPLE_W-1:0] rd0;
  logic signed [SAMPLE_W-1:0] rd1;
  logic signed [SAMPLE_W-1:0] y0r;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] y;
  logic signed [FB_W-1:0]     fb;

  logic signed [SAMPLE_W-1:0] mem [LINE_LENGTH];

  // combinational
  logic [DELAY_W-1:0]         d_sel;
  logic [PW:0]                pos_diff;
  logic [PW:0]                pos_wrap;
  logic [PW-1:0]              pos;
  logic [AW-1:0]              idx_c;
  logic [AW-1:0]              nxt_c;
  logic signed [SAMPLE_W-1:0] y0m;
  logic signed [SAMPLE_W-1:0] y1m;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [FRAC_BITS:0]  frac_s;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [PROD_W-1:0]   prod_sh;
  logic signed [SUM_W-1:0]    y_sum;
  logic signed [SAMPLE_W-1:0] y_c;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [FB_W-1:0]     fb_c;
  logic signed [FB_W-1:0]     fb_sh;
  logic signed [SUM_W-1:0]    w_sum;
  logic signed [SAMPLE_W-1:0] w;

  // clamp and read position
  assign d_sel    = (in_item.delay_q8 > DMAX) ? DMAX : in_item.delay_q8;
  assign pos_diff = {1'b0, wp, {FRAC_BITS{1'b0}}} - {1'b0, dclamp};
  assign pos_wrap = pos_diff + SPAN;
  assign pos      = pos_diff[PW] ? pos_wrap[PW-1:0] : pos_diff[PW-1:0];
  assign idx_c    = pos[PW-1:FRAC_BITS];
  assign nxt_c    = (idx_c == LAST) ? '0 : idx_c + AW'(1);

  // entries not yet written read as zero
  assign y0m    = v0 ? rd0 : '0;
  assign y1m    = v1 ? rd1 : '0;
  assign diff   = {y1m[SAMPLE_W-1], y1m} - {y0m[SAMPLE_W-1], y0m};
  assign frac_s = {1'b0, frac};
  assign prod_c = diff * frac_s;

  // floor division by the fraction scale, the sum stays between y0 and y1
  assign prod_sh = prod >>> FRAC_BITS;
  assign y_sum   = {{2{y0r[SAMPLE_W-1]}}, y0r} + prod_sh[SUM_W-1:0];
  assign y_c     = interp ? y_sum[SAMPLE_W-1:0] : y0r;

  assign gain_s = {1'b0, gain};
  assign fb_c   = y * gain_s;

  // feedback sum with saturation
  assign fb_sh = fb >>> GAIN_FRAC;
  assign w_sum = {{2{x[SAMPLE_W-1]}}, x} + fb_sh[SUM_W-1:0];
  always_comb begin
    priority if (w_sum > SAT_MAX) begin
      w = SAT_MAX[SAMPLE_W-1:0];
    end else if (w_sum < SAT_MIN) begin
      w = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      w = w_sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= '0;
      interp <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_item.index == REG_FEEDBACK_GAIN) begin
        gain <= cfg_item.value[GAIN_W-1:0];
      end else if (cfg_item.index == REG_INTERPOLATE_ENABLE) begin
        interp <= cfg_item.value[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (cmd.commit) begin
      if (wp == LAST) begin
        wp      <= '0;
        wrapped <= 1'b1;
      end else begin
        wp <= wp + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x      <= in_item.sample_in;
      dclamp <= d_sel[PW-1:0];
    end
    if (cmd.calc_addr) begin
      idx  <= idx_c;
      nxt  <= nxt_c;
      frac <= pos[FRAC_BITS-1:0];
      v0   <= wrapped || (idx_c < wp);
      v1   <= wrapped || (nxt_c < wp);
    end
    if (cmd.mul) begin
      y0r  <= y0m;
      prod <= prod_c;
    end
    if (cmd.mix) begin
      y <= y_c;
    end
    if (cmd.scale) begin
      fb <= fb_c;
    end
  end

  // line store, two read ports and one write port
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd0 <= mem[idx];
      rd1 <= mem[nxt];
    end
    if (cmd.commit) begin
      mem[wp] <= w;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.sample_out <= y;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== sv/modulated_fractional_delay_line_top.sv =====
// top level of the modulated fractional delay line
// depends on mfdl_pkg, mfdl_stream_if, mfdl_ctrl and mfdl_datapath
`default_nettype none

// Modulated fractional delay line with linear interpolation and feedback.
// Each item on the samples channel carries a signed 24-bit sample and a delay
// in samples with 8 fraction bits; delays past LINE_LENGTH-1 samples are
// clamped. The block reads the line at write pointer minus delay (wrapping
// around the line), returns either the linear interpolation of the two
// neighbouring entries or the entry at the truncated position, and then
// writes sample + result * feedback_gain / 32768, saturated to 24 bits, at
// the write pointer. A delay of zero returns the sample written LINE_LENGTH
// items earlier. Items are handled one at a time: after an item is accepted
// it goes through the address, dual-port read, interpolation multiply,
// interpolation add, feedback multiply and write-back steps, and the next
// item is taken only once the write-back is done; write-back waits until
// the output register is free. The result sits in an output
// register, so a slow consumer only stalls the block when a second result is
// ready to go out. The line store needs no clearing pass after reset: entries
// not yet written since reset read as zero, tracked by the write pointer and
// a wrapped flag. Configuration registers are feedback_gain (index 0, Q15)
// and interpolate_enable (index 1); the config channel is always ready and
// should only be written while no item is in flight.
module modulated_fractional_delay_line_top
  import mfdl_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEFAULT
) (
  input wire logic      clk,
  input wire logic      rst,
  mfdl_stream_if.sink   samples,
  mfdl_stream_if.source delayed,
  mfdl_stream_if.sink   cfg
);

  cmd_t      cmd;
  status_t   status;
  in_item_t  in_item;
  cfg_item_t cfg_item;
  out_item_t out_item;
  logic      out_valid;

  // payload views of the channels
  assign in_item  = samples.item;
  assign cfg_item = cfg.item;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  assign delayed.valid = out_valid;
  assign delayed.item  = out_item;

  // sequencer: in_ready is high only between items
  mfdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, arithmetic and output register
  mfdl_datapath #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_valid (cfg.valid),
    .cfg_item  (cfg_item),
    .out_ready (delayed.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== sim/tb_modulated_fractional_delay_line_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for modulated_fractional_delay_line_top: items are predicted by an
// in-bench delay line model and compared as results leave; needs mfdl_pkg, mfdl_stream_if, rtl

module tb_modulated_fractional_delay_line_top;
  import mfdl_pkg::*;

  localparam int LINE_LEN     = 4096;
  localparam int PTR_W        = $clog2(LINE_LEN);
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam longint CYCLE_LIMIT = 1000000;

  localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'((LINE_LEN - 1) << FRAC_BITS);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;
  localparam logic [GAIN_W-1:0] GAIN_095  = GAIN_W'(31130);
  localparam logic [GAIN_W-1:0] GAIN_FULL = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #CLK_HALF clk = ~clk;

  mfdl_stream_if #(.T(in_item_t))  samples_ch ();
  mfdl_stream_if #(.T(out_item_t)) delayed_ch ();
  mfdl_stream_if #(.T(cfg_item_t)) cfg_ch ();

  modulated_fractional_delay_line_top #(.LINE_LENGTH(LINE_LEN)) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .delayed(delayed_ch),
    .cfg    (cfg_ch)
  );

  // mirror of the block state and registers
  logic signed [SAMPLE_W-1:0] line_mirror [LINE_LEN];
  logic [PTR_W-1:0]           wp_mirror;
  logic [GAIN_W-1:0]          gain_mirror;
  logic                       interp_mirror;

  out_item_t expected_samples [$];

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_left     = 0;
  int     failures      = 0;
  int     items_sent    = 0;
  int     results_checked = 0;
  longint cycles        = 0;

  // one step of the delay line: read at write pointer minus delay, then write back
  function automatic logic signed [SAMPLE_W-1:0] compute_delayed_sample(
      input logic signed [SAMPLE_W-1:0] x,
      input logic [DELAY_W-1:0]         delay);
    longint unsigned d;
    longint unsigned pos;
    longint unsigned span;
    logic [PTR_W-1:0] idx;
    logic [PTR_W-1:0] nxt;
    logic [FRAC_BITS-1:0] frac;
    longint y0;
    longint y1;
    longint y;
    longint w;
    span = longint'(LINE_LEN) << FRAC_BITS;
    d = (delay > DELAY_MAX) ? DELAY_MAX : delay;
    pos = (longint'(wp_mirror) << FRAC_BITS) + span - d;
    if (pos >= span) begin
      pos = pos - span;
    end
    idx  = pos[FRAC_BITS +: PTR_W];
    frac = pos[FRAC_BITS-1:0];
    nxt  = idx + 1'b1;
    y0 = line_mirror[idx];
    if (interp_mirror) begin
      y1 = line_mirror[nxt];
      y = y0 + ((longint'(frac) * (y1 - y0)) >>> FRAC_BITS);
    end else begin
      y = y0;
    end
    w = longint'(x) + ((y * longint'(gain_mirror)) >>> GAIN_FRAC);
    if (w > longint'(SAMPLE_MAX)) begin
      w = longint'(SAMPLE_MAX);
    end
    if (w < longint'(SAMPLE_MIN)) begin
      w = longint'(SAMPLE_MIN);
    end
    line_mirror[wp_mirror] = w[SAMPLE_W-1:0];
    wp_mirror = wp_mirror + 1'b1;
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    int          near_zero;
    r = $urandom();
    near_zero = $urandom_range(0, 511) - 256;
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return near_zero[SAMPLE_W-1:0];
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] random_delay();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: return r[DELAY_W-1:0];                 // mostly far past the line
      1: return DELAY_MAX;
      2: return '0;
      3: return {12'd0, r[3:0], 8'd0};          // short whole-sample delays
      4: return {12'd0, r[11:0]};               // under 16 samples, fractional
      default: return {4'd0, r[19:0]};
    endcase
  endfunction

  // scoreboard: predicts on every accepted input item, checks every accepted result
  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t observed;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.item.index)
          REG_FEEDBACK_GAIN:      gain_mirror = cfg_ch.item.value[GAIN_W-1:0];
          REG_INTERPOLATE_ENABLE: interp_mirror = cfg_ch.item.value[0];
          default: ;
        endcase
      end
      if (samples_ch.valid && samples_ch.ready) begin
        predicted.sample_out = compute_delayed_sample(samples_ch.item.sample_in,
                                                      samples_ch.item.delay_q8);
        expected_samples.push_back(predicted);
        items_sent++;
      end
      if (delayed_ch.valid && delayed_ch.ready) begin
        observed = delayed_ch.item;
        if (expected_samples.size() == 0) begin
          $error("sample_out: expected no item, got %0d", observed.sample_out);
          failures++;
        end else begin
          predicted = expected_samples.pop_front();
          results_checked++;
          if (observed.sample_out !== predicted.sample_out) begin
            $error("sample_out: expected %0d, got %0d", predicted.sample_out,
                   observed.sample_out);
            failures++;
          end
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      delayed_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      delayed_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance with valid still high
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic [DELAY_W-1:0] delay);
    if ($urandom_range(99) < send_idle_pct) begin
      samples_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    samples_ch.valid <= 1'b1;
    samples_ch.item  <= '{sample_in: x, delay_q8: delay};
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
  endtask

  // sender pauses until every expected result is back and the block has settled
  task automatic wait_for_results();
    samples_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // writes both registers back to back, valid held high across the two items
  task automatic set_config(input logic [GAIN_W-1:0] gain, input logic interp);
    cfg_ch.valid <= 1'b1;
    cfg_ch.item  <= '{index: REG_FEEDBACK_GAIN, value: CFG_VALUE_W'(gain)};
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.item  <= '{index: REG_INTERPOLATE_ENABLE, value: CFG_VALUE_W'(interp)};
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // extremes, clamping, last-entry neighbour, saturation, both read modes
  task automatic test_directed_edges();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(GAIN_ZERO, 1'b1);
    // zero delay before the line has wrapped reads a cleared entry
    send_sample(SAMPLE_MAX, '0);
    send_sample(SAMPLE_MIN, 24'h000100);
    // halfway between the two extremes, negative floor
    send_sample(24'sd1000, 24'h000180);
    // delays past the line are clamped
    send_sample(-24'sd77, 24'hFFFFFF);
    send_sample(24'sd5, DELAY_MAX + 1'b1);
    send_sample(24'sd9, DELAY_MAX);
    // half a sample behind entry zero: interpolates last entry with entry zero
    send_sample(-24'sd3, DELAY_W'({wp_mirror, 8'h80}));
    wait_for_results();

    // full-scale feedback with truncated reads drives the write into saturation
    set_config(GAIN_FULL, 1'b0);
    send_sample(SAMPLE_MAX, DELAY_W'({wp_mirror, 8'h00}));
    send_sample(SAMPLE_MIN, DELAY_W'({wp_mirror - 1'b1, 8'h00}));
    send_sample(24'sd12345, 24'h0000C0);
    send_sample(SAMPLE_MAX, 24'h000001);
    send_sample(SAMPLE_MIN, 24'h0000FF);
    wait_for_results();

    set_config(GAIN_095, 1'b1);
    send_sample(SAMPLE_MAX, 24'h000240);
    send_sample(SAMPLE_MIN, 24'h000340);
    send_sample(-24'sd1, 24'h0001FF);
    send_sample(24'sd1, 24'h000101);
    wait_for_results();
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(GAIN_095, 1'b1);
    hold_left = HOLD_CYCLES;
    repeat (16) send_sample(random_sample(), random_delay());
    wait_for_results();
  endtask

  // random delays including short ones, zero delay and the last-entry neighbour
  task automatic test_short_delays();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(GAIN_095, 1'b1);
    repeat (32) send_sample(random_sample(), random_delay());
    send_sample(SAMPLE_MAX, '0);
    send_sample(SAMPLE_MIN, '0);
    send_sample(24'sd42, DELAY_W'({wp_mirror, 8'h80}));
    wait_for_results();
  endtask

  // segments of random or swept delays, a fresh register setting before each
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int seg;
    int sweep_pos;
    int sweep_lo;
    int sweep_hi;
    int sweep_step;
    bit sweeping;
    logic [GAIN_W-1:0] gain;
    logic [DELAY_W-1:0] d;
    sent = 0;
    while (sent < n_items) begin
      wait_for_results();
      case ($urandom_range(4))
        0: gain = GAIN_ZERO;
        1: gain = GAIN_095;
        2: gain = GAIN_FULL;
        default: gain = GAIN_W'($urandom_range(0, 32767));
      endcase
      set_config(gain, 1'($urandom_range(1)));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      // modulated delay: a triangle sweep, as a chorus or flanger would drive it
      sweeping   = 1'($urandom_range(1));
      sweep_lo   = $urandom_range(0, 24'h040000);
      sweep_hi   = sweep_lo + $urandom_range(256, 24'h0C0000);
      sweep_pos  = sweep_lo;
      sweep_step = $urandom_range(1, 600);
      seg = $urandom_range(20, 60);
      repeat (seg) begin
        if (sweeping) begin
          d = DELAY_W'(sweep_pos);
          sweep_pos += sweep_step;
          if (sweep_pos > sweep_hi || sweep_pos < sweep_lo) begin
            sweep_step = -sweep_step;
          end
        end else begin
          d = random_delay();
        end
        send_sample(random_sample(), d);
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    samples_ch.valid = 1'b0;
    samples_ch.item  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.item      = '0;
    delayed_ch.ready = 1'b0;
    for (int i = 0; i < LINE_LEN; i++) begin
      line_mirror[i] = '0;
    end
    wp_mirror     = '0;
    gain_mirror   = '0;
    interp_mirror = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_output_stall();
    test_short_delays();
    test_random_traffic(12, 55, 180);
    test_random_traffic(55, 12, 180);
    test_random_traffic(0, 0, 180);

    if (expected_samples.size() != 0) begin
      $error("sample_out: %0d expected items never arrived", expected_samples.size());
      failures++;
    end
    $display("tb: %0d items sent, %0d results checked, write pointer ended at %0d",
             items_sent, results_checked, wp_mirror);
    $display("tb: gain zero to full scale, both read modes, long output stall, %0d mismatches",
             failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mfdl_pkg.sv
sv/mfdl_stream_if.sv
sv/mfdl_ctrl.sv
sv/mfdl_datapath.sv
sv/modulated_fractional_delay_line_top.sv
sim/tb_modulated_fractional_delay_line_top.sv
